@@ hdl/lrupr_pkg.sv @@
// shared constants and types for the lru page replacement block
package lrupr_pkg;

    localparam int NFRAMES = 16;
    localparam int IDX_W   = $clog2(NFRAMES);
    localparam int CNT_W   = $clog2(NFRAMES + 1);
    localparam int CFG_W   = 5;
    localparam int PAGE_W  = 16;
    localparam int AGE_W   = 8;
    localparam int FAULT_W = 32;

    localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(NFRAMES);

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        logic             live;
        logic             frame_valid;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } scan_beat_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic              any_valid;
        logic [IDX_W-1:0]  victim_idx;
        logic [AGE_W-1:0]  victim_age;
        logic [PAGE_W-1:0] victim_page;
    } scan_res_t;

endpackage

@@ hdl/lrupr_scan.sv @@
// running match and oldest-frame search over the frame beats of one reference
module lrupr_scan
    import lrupr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PAGE_W-1:0] page,
    input  scan_beat_t        beat,
    output scan_res_t         res
);

    scan_res_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.hit       <= 1'b0;
            res_reg.any_valid <= 1'b0;
        end else if (start) begin
            res_reg.hit       <= 1'b0;
            res_reg.any_valid <= 1'b0;
        end else if (beat.live && beat.frame_valid) begin
            if (!res_reg.hit && (beat.entry.page == page)) begin
                res_reg.hit     <= 1'b1;
                res_reg.hit_idx <= beat.idx;
            end
            // strict compare keeps the lowest index on ties
            if (!res_reg.any_valid || (beat.entry.age > res_reg.victim_age)) begin
                res_reg.any_valid   <= 1'b1;
                res_reg.victim_idx  <= beat.idx;
                res_reg.victim_age  <= beat.entry.age;
                res_reg.victim_page <= beat.entry.page;
            end
        end
    end

    assign res = res_reg;

endmodule

@@ hdl/lru_page_replacement_top.sv @@
// lru page replacement with saturating per-frame ages held in a frame memory
// a new reference is taken only when idle, after the last result commits; the scan reads one entry a cycle
// the scan reads each frame in use once, writes valid ones back aged on the following cycle
// reset: synchronous active-low, clears valid bits, fill level, fault count, frame_count to 16
// frame page entries are undefined until written and are only used behind their valid bit
module lru_page_replacement_top
    import lrupr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PAGE_W-1:0]  s_page,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [IDX_W-1:0]   m_frame_index,
    output logic               m_evicted_valid,
    output logic [PAGE_W-1:0]  m_evicted_page,
    output logic [FAULT_W-1:0] m_fault_total
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   frame_count_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [IDX_W-1:0]   issue_idx_reg;
    logic               chk_valid_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    entry_t             rd_data_reg;
    logic [NFRAMES-1:0] valid_bits_reg;
    logic [CNT_W-1:0]   fill_level_reg;
    logic [FAULT_W-1:0] fault_count_reg;

    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [IDX_W-1:0]   m_frame_index_reg;
    logic               m_evicted_valid_reg;
    logic [PAGE_W-1:0]  m_evicted_page_reg;

    entry_t             entry_mem [NFRAMES];

    logic [CNT_W-1:0]   n_eff;
    logic [IDX_W-1:0]   last_idx;
    logic               in_fire;
    logic               out_free;
    logic               commit_fire;
    scan_beat_t         beat;
    scan_res_t          scan_res;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic [IDX_W-1:0]   slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic               fill_next;
    logic [FAULT_W-1:0] fault_next;

    // clamp the configured count into 1..NFRAMES
    always_comb begin
        if (frame_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (CNT_W'(frame_count_reg) > CNT_W'(NFRAMES)) begin
            n_eff = CNT_W'(NFRAMES);
        end else begin
            n_eff = CNT_W'(frame_count_reg);
        end
    end

    assign last_idx    = IDX_W'(n_eff - CNT_W'(1));
    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign commit_fire = (state_reg == ST_COMMIT) && out_free;

    assign beat.live        = chk_valid_reg;
    assign beat.frame_valid = valid_bits_reg[chk_idx_reg];
    assign beat.idx         = chk_idx_reg;
    assign beat.entry       = rd_data_reg;

    lrupr_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .page    (page_reg),
        .beat    (beat),
        .res     (scan_res)
    );

    // slot choice once the scan has seen every frame in use
    always_comb begin
        slot      = '0;
        ev_valid  = 1'b0;
        ev_page   = '0;
        fill_next = 1'b0;
        if (scan_res.hit) begin
            slot = scan_res.hit_idx;
        end else if (fill_level_reg < n_eff) begin
            slot      = IDX_W'(fill_level_reg);
            fill_next = 1'b1;
        end else if (scan_res.any_valid) begin
            slot     = scan_res.victim_idx;
            ev_valid = 1'b1;
            ev_page  = scan_res.victim_page;
        end
    end

    always_comb begin
        fault_next = fault_count_reg;
        if (!scan_res.hit && (fault_count_reg != FAULT_MAX)) begin
            fault_next = fault_count_reg + FAULT_W'(1);
        end
    end

    // aged write-back during the scan, new owner with age zero at commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = chk_idx_reg;
        wr_data = rd_data_reg;
        if (commit_fire) begin
            wr_en        = 1'b1;
            wr_addr      = slot;
            wr_data.page = page_reg;
            wr_data.age  = '0;
        end else if (chk_valid_reg && valid_bits_reg[chk_idx_reg]) begin
            wr_en = 1'b1;
            if (rd_data_reg.age != AGE_MAX) begin
                wr_data.age = rd_data_reg.age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[issue_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            frame_count_reg     <= CFG_RESET;
            issue_idx_reg       <= '0;
            chk_valid_reg       <= 1'b0;
            chk_idx_reg         <= '0;
            valid_bits_reg      <= '0;
            fill_level_reg      <= '0;
            fault_count_reg     <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                frame_count_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            chk_valid_reg <= (state_reg == ST_SCAN);
            chk_idx_reg   <= issue_idx_reg;
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        page_reg      <= s_page;
                        issue_idx_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue_idx_reg == last_idx) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (commit_fire) begin
                        valid_bits_reg[slot] <= 1'b1;
                        if (fill_next) begin
                            fill_level_reg <= fill_level_reg + CNT_W'(1);
                        end
                        fault_count_reg     <= fault_next;
                        m_valid_reg         <= 1'b1;
                        m_hit_reg           <= scan_res.hit;
                        m_frame_index_reg   <= slot;
                        m_evicted_valid_reg <= ev_valid;
                        m_evicted_page_reg  <= ev_page;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_frame_index_reg;
    assign m_evicted_valid = m_evicted_valid_reg;
    assign m_evicted_page  = m_evicted_page_reg;
    assign m_fault_total   = fault_count_reg;

    a_slot_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_fire |-> (CNT_W'(slot) < n_eff))
        else $error("chosen frame outside the frames in use");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_level_reg <= CNT_W'(NFRAMES))
        else $error("fill level beyond frame count");

    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_fire && scan_res.hit) |-> valid_bits_reg[scan_res.hit_idx])
        else $error("hit on a frame that is not valid");

    a_idle_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !chk_valid_reg)
        else $error("new reference accepted with a scan beat in flight");

    a_fault_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit_fire && scan_res.hit) |=> $stable(fault_count_reg))
        else $error("fault count moved on a hit");

endmodule
